// ===== rtl/qrv_pkg.sv =====
// qrv_pkg: shared constants, types and width helpers for the quaternion
// vector rotation block. No dependencies; used by every file under rtl.

package qrv_pkg;

   localparam int QREG_W        = 16;
   localparam int Q_W           = QREG_W + 1;
   localparam int VEC_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF = 14;
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 32;
   localparam int CROSS_LAT     = 2;
   localparam int CORR_LAT      = 3;

   typedef enum logic [1:0] {
      CSR_QUAT_X = 2'd0,
      CSR_QUAT_Y = 2'd1,
      CSR_QUAT_Z = 2'd2,
      CSR_QUAT_W = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic signed [Q_W-1:0] x;
      logic signed [Q_W-1:0] y;
      logic signed [Q_W-1:0] z;
      logic signed [Q_W-1:0] w;
   } quat_type;

   // width of one cross product term
   function automatic int cross_width(input int vw);
      return vw + Q_W + 1;
   endfunction

   // width of the correction sum; large enough to hold the rounding offset
   function automatic int sum_width(input int vw, input int f);
      int t;
      t = vw + Q_W + Q_W + 4;
      return (t > 2 * f + 1) ? t : 2 * f + 1;
   endfunction

endpackage

// ===== rtl/quaternion_rotate_vector_top.sv =====
// quaternion_rotate_vector_top: quaternion vector rotation, top level with
// register file, input stage and saturating output stage.
// Depends on qrv_pkg, qrv_cross and qrv_corr.
//
// Usage:
//   Program quat_x/y/z/w (Q1.14, byte offsets 0x0/0x4/0x8/0xC) over the
//   APB port while no word is in flight. Reset loads the identity.
//   A word is taken at each rising edge with start high; busy stays low,
//   so a new word may be issued every cycle. req_action selects the
//   conjugate (inverse rotation).
//   rsp_valid pulses for one cycle with the rotated vector and the clip
//   flag once the word has passed the input register, two cross-product
//   stages, three correction stages and the output register.
//   Throughput is one word per cycle; the receiver cannot stall, results
//   come out in issue order.
//   Reset flushes all words in flight.

module quaternion_rotate_vector_top #(
   parameter int VEC_WIDTH      = qrv_pkg::VEC_WIDTH_DEF,
   parameter int QUAT_FRAC_BITS = qrv_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_action,
   input  logic signed [VEC_WIDTH-1:0]      req_vec_x,
   input  logic signed [VEC_WIDTH-1:0]      req_vec_y,
   input  logic signed [VEC_WIDTH-1:0]      req_vec_z,
   output logic                             rsp_valid,
   output logic signed [VEC_WIDTH-1:0]      rsp_rot_x,
   output logic signed [VEC_WIDTH-1:0]      rsp_rot_y,
   output logic signed [VEC_WIDTH-1:0]      rsp_rot_z,
   output logic                             rsp_clipped,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [qrv_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [qrv_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [qrv_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   localparam int QW   = qrv_pkg::QREG_W;
   localparam int Q_W  = qrv_pkg::Q_W;
   localparam int CW   = qrv_pkg::cross_width(VEC_WIDTH);
   localparam int SW   = qrv_pkg::sum_width(VEC_WIDTH, QUAT_FRAC_BITS);
   localparam int RW   = SW + 1;
   localparam int DLY  = qrv_pkg::CROSS_LAT + qrv_pkg::CORR_LAT;
   localparam int LAT  = DLY + 2;
   localparam logic [31:0] W_ONE = 32'(1) << QUAT_FRAC_BITS;
   localparam logic signed [RW-1:0] R_MAX = (RW'(1) <<< (VEC_WIDTH - 1)) - RW'(1);
   localparam logic signed [RW-1:0] R_MIN = -(RW'(1) <<< (VEC_WIDTH - 1));
   localparam logic signed [VEC_WIDTH-1:0] OUT_MAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
   localparam logic signed [VEC_WIDTH-1:0] OUT_MIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

   // register file
   logic signed [QW-1:0]  quat_x_ff, quat_y_ff, quat_z_ff, quat_w_ff;
   logic                  csr_wr;
   qrv_pkg::csr_reg_type  csr_idx;

   // input stage
   logic                     a_valid_ff;
   qrv_pkg::quat_type        a_quat_in, a_quat_ff;
   logic signed [VEC_WIDTH-1:0] a_vx_ff, a_vy_ff, a_vz_ff;

   // cross product outputs
   logic                  c_valid;
   qrv_pkg::quat_type     c_quat;
   logic signed [CW-1:0]  c_x, c_y, c_z;

   // correction outputs
   logic                  f_valid_x, f_valid_y, f_valid_z, f_valid;
   logic signed [SW-1:0]  delta_w [3];

   // vector delay line
   logic signed [VEC_WIDTH-1:0] vx_dly_ff [DLY];
   logic signed [VEC_WIDTH-1:0] vy_dly_ff [DLY];
   logic signed [VEC_WIDTH-1:0] vz_dly_ff [DLY];
   logic signed [VEC_WIDTH-1:0] v_f [3];

   // output stage
   logic signed [RW-1:0]        r_w [3];
   logic signed [VEC_WIDTH-1:0] rot_in [3];
   logic [2:0]                  clip_w;
   logic                        out_valid_ff, out_clip_ff;
   logic signed [VEC_WIDTH-1:0] out_x_ff, out_y_ff, out_z_ff;

   // ---------------- register file ----------------
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = qrv_pkg::csr_reg_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_x_ff <= '0;
         quat_y_ff <= '0;
         quat_z_ff <= '0;
         quat_w_ff <= W_ONE[QW-1:0];
      end else if (csr_wr) begin
         unique case (csr_idx)
            qrv_pkg::CSR_QUAT_X: quat_x_ff <= pwdata[QW-1:0];
            qrv_pkg::CSR_QUAT_Y: quat_y_ff <= pwdata[QW-1:0];
            qrv_pkg::CSR_QUAT_Z: quat_z_ff <= pwdata[QW-1:0];
            qrv_pkg::CSR_QUAT_W: quat_w_ff <= pwdata[QW-1:0];
            default:             quat_w_ff <= quat_w_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         qrv_pkg::CSR_QUAT_X: prdata = {{(qrv_pkg::CSR_DATA_W-QW){1'b0}}, quat_x_ff};
         qrv_pkg::CSR_QUAT_Y: prdata = {{(qrv_pkg::CSR_DATA_W-QW){1'b0}}, quat_y_ff};
         qrv_pkg::CSR_QUAT_Z: prdata = {{(qrv_pkg::CSR_DATA_W-QW){1'b0}}, quat_z_ff};
         qrv_pkg::CSR_QUAT_W: prdata = {{(qrv_pkg::CSR_DATA_W-QW){1'b0}}, quat_w_ff};
         default:             prdata = '0;
      endcase
   end

   // ---------------- input stage ----------------
   assign busy = 1'b0;

   // conjugate: 17-bit vector part so that -(-2.0) stays +2.0
   always_comb begin
      a_quat_in.w = Q_W'(quat_w_ff);
      if (req_action) begin
         a_quat_in.x = -Q_W'(quat_x_ff);
         a_quat_in.y = -Q_W'(quat_y_ff);
         a_quat_in.z = -Q_W'(quat_z_ff);
      end else begin
         a_quat_in.x = Q_W'(quat_x_ff);
         a_quat_in.y = Q_W'(quat_y_ff);
         a_quat_in.z = Q_W'(quat_z_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      a_quat_ff <= a_quat_in;
      a_vx_ff   <= req_vec_x;
      a_vy_ff   <= req_vec_y;
      a_vz_ff   <= req_vec_z;
   end

   // ---------------- datapath ----------------
   qrv_cross #(
      .VEC_WIDTH (VEC_WIDTH)
   ) u_cross (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid_ff),
      .in_quat   (a_quat_ff),
      .in_vx     (a_vx_ff),
      .in_vy     (a_vy_ff),
      .in_vz     (a_vz_ff),
      .out_valid (c_valid),
      .out_quat  (c_quat),
      .out_cx    (c_x),
      .out_cy    (c_y),
      .out_cz    (c_z)
   );

   // x: w*cx + qy*cz - qz*cy
   qrv_corr #(
      .VEC_WIDTH (VEC_WIDTH),
      .FRAC_BITS (QUAT_FRAC_BITS)
   ) u_corr_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid),
      .in_a0     (c_quat.w),
      .in_a1     (c_quat.y),
      .in_a2     (c_quat.z),
      .in_b0     (c_x),
      .in_b1     (c_z),
      .in_b2     (c_y),
      .out_valid (f_valid_x),
      .out_delta (delta_w[0])
   );

   // y: w*cy + qz*cx - qx*cz
   qrv_corr #(
      .VEC_WIDTH (VEC_WIDTH),
      .FRAC_BITS (QUAT_FRAC_BITS)
   ) u_corr_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid),
      .in_a0     (c_quat.w),
      .in_a1     (c_quat.z),
      .in_a2     (c_quat.x),
      .in_b0     (c_y),
      .in_b1     (c_x),
      .in_b2     (c_z),
      .out_valid (f_valid_y),
      .out_delta (delta_w[1])
   );

   // z: w*cz + qx*cy - qy*cx
   qrv_corr #(
      .VEC_WIDTH (VEC_WIDTH),
      .FRAC_BITS (QUAT_FRAC_BITS)
   ) u_corr_z (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid),
      .in_a0     (c_quat.w),
      .in_a1     (c_quat.x),
      .in_a2     (c_quat.y),
      .in_b0     (c_z),
      .in_b1     (c_y),
      .in_b2     (c_x),
      .out_valid (f_valid_z),
      .out_delta (delta_w[2])
   );

   assign f_valid = f_valid_x && f_valid_y && f_valid_z;

   always_ff @(posedge clock) begin
      vx_dly_ff[0] <= a_vx_ff;
      vy_dly_ff[0] <= a_vy_ff;
      vz_dly_ff[0] <= a_vz_ff;
      for (int i = 1; i < DLY; i++) begin
         vx_dly_ff[i] <= vx_dly_ff[i-1];
         vy_dly_ff[i] <= vy_dly_ff[i-1];
         vz_dly_ff[i] <= vz_dly_ff[i-1];
      end
   end

   assign v_f[0] = vx_dly_ff[DLY-1];
   assign v_f[1] = vy_dly_ff[DLY-1];
   assign v_f[2] = vz_dly_ff[DLY-1];

   // ---------------- output stage ----------------
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         r_w[k] = RW'(v_f[k]) + RW'(delta_w[k]);
         if (r_w[k] > R_MAX) begin
            rot_in[k] = OUT_MAX;
            clip_w[k] = 1'b1;
         end else if (r_w[k] < R_MIN) begin
            rot_in[k] = OUT_MIN;
            clip_w[k] = 1'b1;
         end else begin
            rot_in[k] = r_w[k][VEC_WIDTH-1:0];
            clip_w[k] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= f_valid;
      end
   end

   always_ff @(posedge clock) begin
      out_x_ff    <= rot_in[0];
      out_y_ff    <= rot_in[1];
      out_z_ff    <= rot_in[2];
      out_clip_ff <= |clip_w;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_rot_x   = out_x_ff;
   assign rsp_rot_y   = out_y_ff;
   assign rsp_rot_z   = out_z_ff;
   assign rsp_clipped = out_clip_ff;

   // ---------------- assertions ----------------
   a_lat_fwd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("accepted word did not come out after the pipeline latency");

   a_lat_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result strobe without a matching accepted word");

   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
         (rsp_rot_x == OUT_MAX || rsp_rot_x == OUT_MIN ||
          rsp_rot_y == OUT_MAX || rsp_rot_y == OUT_MIN ||
          rsp_rot_z == OUT_MAX || rsp_rot_z == OUT_MIN))
      else $error("clip flag set with no component at a rail");

endmodule

// ===== rtl/qrv_cross.sv =====
// qrv_cross: two-stage pipeline for c = q x v (products, then differences).
// Depends on qrv_pkg.

module qrv_cross #(
   parameter int VEC_WIDTH = qrv_pkg::VEC_WIDTH_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            in_valid,
   input  qrv_pkg::quat_type                               in_quat,
   input  logic signed [VEC_WIDTH-1:0]                     in_vx,
   input  logic signed [VEC_WIDTH-1:0]                     in_vy,
   input  logic signed [VEC_WIDTH-1:0]                     in_vz,
   output logic                                            out_valid,
   output qrv_pkg::quat_type                               out_quat,
   output logic signed [qrv_pkg::cross_width(VEC_WIDTH)-1:0] out_cx,
   output logic signed [qrv_pkg::cross_width(VEC_WIDTH)-1:0] out_cy,
   output logic signed [qrv_pkg::cross_width(VEC_WIDTH)-1:0] out_cz
);

   localparam int CW = qrv_pkg::cross_width(VEC_WIDTH);
   localparam int PW = qrv_pkg::Q_W + VEC_WIDTH;

   logic                 b_valid_ff, c_valid_ff;
   qrv_pkg::quat_type    b_quat_ff, c_quat_ff;
   logic signed [PW-1:0] p_yz_in, p_zy_in, p_zx_in, p_xz_in, p_xy_in, p_yx_in;
   logic signed [PW-1:0] p_yz_ff, p_zy_ff, p_zx_ff, p_xz_ff, p_xy_ff, p_yx_ff;
   logic signed [CW-1:0] cx_in, cy_in, cz_in;
   logic signed [CW-1:0] cx_ff, cy_ff, cz_ff;

   always_comb begin
      p_yz_in = $signed(in_quat.y) * in_vz;
      p_zy_in = $signed(in_quat.z) * in_vy;
      p_zx_in = $signed(in_quat.z) * in_vx;
      p_xz_in = $signed(in_quat.x) * in_vz;
      p_xy_in = $signed(in_quat.x) * in_vy;
      p_yx_in = $signed(in_quat.y) * in_vx;
      cx_in   = CW'(p_yz_ff) - CW'(p_zy_ff);
      cy_in   = CW'(p_zx_ff) - CW'(p_xz_ff);
      cz_in   = CW'(p_xy_ff) - CW'(p_yx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= in_valid;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_quat_ff <= in_quat;
      p_yz_ff   <= p_yz_in;
      p_zy_ff   <= p_zy_in;
      p_zx_ff   <= p_zx_in;
      p_xz_ff   <= p_xz_in;
      p_xy_ff   <= p_xy_in;
      p_yx_ff   <= p_yx_in;
      c_quat_ff <= b_quat_ff;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      cz_ff     <= cz_in;
   end

   assign out_valid = c_valid_ff;
   assign out_quat  = c_quat_ff;
   assign out_cx    = cx_ff;
   assign out_cy    = cy_ff;
   assign out_cz    = cz_ff;

endmodule

// ===== rtl/qrv_corr.sv =====
// qrv_corr: three-stage pipeline for one rounded correction term
// delta = round(2*(a0*b0 + a1*b1 - a2*b2) / 2^(2F)). Depends on qrv_pkg.

module qrv_corr #(
   parameter int VEC_WIDTH = qrv_pkg::VEC_WIDTH_DEF,
   parameter int FRAC_BITS = qrv_pkg::FRAC_BITS_DEF
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   in_valid,
   input  logic signed [qrv_pkg::Q_W-1:0]                         in_a0,
   input  logic signed [qrv_pkg::Q_W-1:0]                         in_a1,
   input  logic signed [qrv_pkg::Q_W-1:0]                         in_a2,
   input  logic signed [qrv_pkg::cross_width(VEC_WIDTH)-1:0]      in_b0,
   input  logic signed [qrv_pkg::cross_width(VEC_WIDTH)-1:0]      in_b1,
   input  logic signed [qrv_pkg::cross_width(VEC_WIDTH)-1:0]      in_b2,
   output logic                                                   out_valid,
   output logic signed [qrv_pkg::sum_width(VEC_WIDTH, FRAC_BITS)-1:0] out_delta
);

   localparam int CW  = qrv_pkg::cross_width(VEC_WIDTH);
   localparam int LO  = CW / 2;
   localparam int HW  = CW - LO;
   localparam int HPW = qrv_pkg::Q_W + HW;
   localparam int LPW = qrv_pkg::Q_W + LO + 1;
   localparam int HSW = HPW + 2;
   localparam int LSW = LPW + 2;
   localparam int SW  = qrv_pkg::sum_width(VEC_WIDTH, FRAC_BITS);
   localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) <<< (2 * FRAC_BITS - 2);

   logic signed [qrv_pkg::Q_W-1:0] a_w [3];
   logic signed [CW-1:0]           b_w [3];
   logic signed [HPW-1:0]          ph_in [3];
   logic signed [HPW-1:0]          ph_ff [3];
   logic signed [LPW-1:0]          pl_in [3];
   logic signed [LPW-1:0]          pl_ff [3];
   logic signed [HSW-1:0]          hs_in, hs_ff;
   logic signed [LSW-1:0]          ls_in, ls_ff;
   logic signed [SW-1:0]           t_w, rnd_w, delta_in, delta_ff;
   logic                           d_valid_ff, e_valid_ff, f_valid_ff;

   assign a_w[0] = in_a0;
   assign a_w[1] = in_a1;
   assign a_w[2] = in_a2;
   assign b_w[0] = in_b0;
   assign b_w[1] = in_b1;
   assign b_w[2] = in_b2;

   // split each cross term into a signed high half and an unsigned low half
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ph_in[k] = a_w[k] * $signed(b_w[k][CW-1:LO]);
         pl_in[k] = a_w[k] * $signed({1'b0, b_w[k][LO-1:0]});
      end
      hs_in    = HSW'(ph_ff[0]) + HSW'(ph_ff[1]) - HSW'(ph_ff[2]);
      ls_in    = LSW'(pl_ff[0]) + LSW'(pl_ff[1]) - LSW'(pl_ff[2]);
      t_w      = (SW'(hs_ff) <<< LO) + SW'(ls_ff);
      rnd_w    = t_w + ROUND_HALF;
      delta_in = rnd_w >>> (2 * FRAC_BITS - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= in_valid;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         ph_ff[k] <= ph_in[k];
         pl_ff[k] <= pl_in[k];
      end
      hs_ff    <= hs_in;
      ls_ff    <= ls_in;
      delta_ff <= delta_in;
   end

   assign out_valid = f_valid_ff;
   assign out_delta = delta_ff;

endmodule

// ===== tb/quaternion_rotate_vector_top_test.sv =====
// Self-checking testbench for quaternion_rotate_vector_top: rotates vectors through the
// block and compares every result word against an internal fixed-point rotation model.
// Depends on qrv_pkg and the RTL under rtl.
`timescale 1ns / 1ps

module quaternion_rotate_vector_top_test;

   localparam int VW = qrv_pkg::VEC_WIDTH_DEF;
   localparam int FB = qrv_pkg::FRAC_BITS_DEF;
   localparam int QW = qrv_pkg::QREG_W;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 10;

   typedef struct {
      logic signed [VW-1:0] x;
      logic signed [VW-1:0] y;
      logic signed [VW-1:0] z;
      logic                 clip;
   } rotation_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_action = 1'b0;
   logic signed [VW-1:0] req_vec_x = '0;
   logic signed [VW-1:0] req_vec_y = '0;
   logic signed [VW-1:0] req_vec_z = '0;
   logic rsp_valid;
   logic signed [VW-1:0] rsp_rot_x;
   logic signed [VW-1:0] rsp_rot_y;
   logic signed [VW-1:0] rsp_rot_z;
   logic rsp_clipped;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [qrv_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [qrv_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [qrv_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   logic signed [QW-1:0] quat_cfg [4];
   rotation_type pending_rotations [$];
   rotation_type want_word;
   int mismatch_count = 0;
   int idle_cycles = 0;

   quaternion_rotate_vector_top u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_vec_x(req_vec_x), .req_vec_y(req_vec_y),
      .req_vec_z(req_vec_z), .rsp_valid(rsp_valid), .rsp_rot_x(rsp_rot_x),
      .rsp_rot_y(rsp_rot_y), .rsp_rot_z(rsp_rot_z), .rsp_clipped(rsp_clipped),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   function automatic longint round_correction(longint t);
      return (t + (longint'(1) <<< (2 * FB - 2))) >>> (2 * FB - 1);
   endfunction

   function automatic logic signed [VW-1:0] clamp_component(longint value, inout logic clip);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (VW - 1)) - 1;
      lo = -(longint'(1) <<< (VW - 1));
      if (value > hi) begin
         clip = 1'b1;
         return hi[VW-1:0];
      end
      if (value < lo) begin
         clip = 1'b1;
         return lo[VW-1:0];
      end
      return value[VW-1:0];
   endfunction

   // v + 2*(w*(q x v) + q x (q x v)); conjugate negates q
   function automatic rotation_type rotate_vector(logic inverse, logic signed [VW-1:0] vx_in,
                                                  logic signed [VW-1:0] vy_in,
                                                  logic signed [VW-1:0] vz_in);
      longint qx, qy, qz, qw, vx, vy, vz, cx, cy, cz;
      longint rx, ry, rz;
      rotation_type res;
      qx = longint'(quat_cfg[qrv_pkg::CSR_QUAT_X]);
      qy = longint'(quat_cfg[qrv_pkg::CSR_QUAT_Y]);
      qz = longint'(quat_cfg[qrv_pkg::CSR_QUAT_Z]);
      qw = longint'(quat_cfg[qrv_pkg::CSR_QUAT_W]);
      vx = longint'(vx_in);
      vy = longint'(vy_in);
      vz = longint'(vz_in);
      if (inverse) begin
         qx = -qx;
         qy = -qy;
         qz = -qz;
      end
      cx = qy * vz - qz * vy;
      cy = qz * vx - qx * vz;
      cz = qx * vy - qy * vx;
      rx = vx + round_correction(qw * cx + qy * cz - qz * cy);
      ry = vy + round_correction(qw * cy + qz * cx - qx * cz);
      rz = vz + round_correction(qw * cz + qx * cy - qy * cx);
      res.clip = 1'b0;
      res.x = clamp_component(rx, res.clip);
      res.y = clamp_component(ry, res.clip);
      res.z = clamp_component(rz, res.clip);
      return res;
   endfunction

   function automatic logic signed [VW-1:0] random_component();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      if (pick <= 2)
         return VW'($signed($urandom_range(0, 128)) - 64);
      return VW'($urandom);
   endfunction

   function automatic int random_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50)
         return 0;
      if (pick < 85)
         return $urandom_range(1, 3);
      if (pick < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic send_vector(logic action, logic signed [VW-1:0] x, logic signed [VW-1:0] y,
                              logic signed [VW-1:0] z);
      start <= 1'b1;
      req_action <= action;
      req_vec_x <= x;
      req_vec_y <= y;
      req_vec_z <= z;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      pending_rotations.push_back(rotate_vector(action, x, y, z));
   endtask

   // lowered start with junk on the payload
   task automatic idle_sender(int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         req_action <= 1'($urandom_range(0, 1));
         req_vec_x <= VW'($urandom);
         req_vec_y <= VW'($urandom);
         req_vec_z <= VW'($urandom);
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_rotations.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(qrv_pkg::csr_reg_type idx, logic signed [QW-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= {{(qrv_pkg::CSR_DATA_W - QW){value[QW-1]}}, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      quat_cfg[idx] = value;
   endtask

   task automatic set_quat(logic signed [QW-1:0] x, logic signed [QW-1:0] y,
                           logic signed [QW-1:0] z, logic signed [QW-1:0] w);
      wait_drained();
      csr_write(qrv_pkg::CSR_QUAT_X, x);
      csr_write(qrv_pkg::CSR_QUAT_Y, y);
      csr_write(qrv_pkg::CSR_QUAT_Z, z);
      csr_write(qrv_pkg::CSR_QUAT_W, w);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_random_unit_quat();
      real a, b, c, d, n;
      a = real'($urandom_range(0, 2000)) - 1000.0;
      b = real'($urandom_range(0, 2000)) - 1000.0;
      c = real'($urandom_range(0, 2000)) - 1000.0;
      d = real'($urandom_range(0, 2000)) - 1000.0;
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) begin
         d = 1.0;
         n = 1.0;
      end
      set_quat(QW'($rtoi(a / n * 16384.0)), QW'($rtoi(b / n * 16384.0)),
               QW'($rtoi(c / n * 16384.0)), QW'($rtoi(d / n * 16384.0)));
   endtask

   task automatic test_identity();
      send_vector(1'b0, 16'sd0, 16'sd0, 16'sd0);
      idle_sender(random_gap());
      send_vector(1'b1, 16'sh7fff, 16'sh8000, 16'sd12345);
      idle_sender(random_gap());
      send_vector(1'b0, 16'sh8000, 16'sh8000, 16'sh8000);
      send_vector(1'b1, 16'sh7fff, 16'sh7fff, 16'sh7fff);
   endtask

   task automatic test_fixed_turns();
      set_quat(16'sd0, 16'sd0, 16'sd11585, 16'sd11585);
      send_vector(1'b0, 16'sd1000, 16'sd0, 16'sd0);
      send_vector(1'b1, 16'sd1000, 16'sd0, 16'sd0);
      idle_sender(random_gap());
      send_vector(1'b0, 16'sd0, -16'sd2000, 16'sd300);
      send_vector(1'b1, 16'sh7fff, 16'sh8000, 16'sd0);
      set_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
      send_vector(1'b0, 16'sd100, 16'sd200, 16'sd300);
      send_vector(1'b1, 16'sh8000, 16'sd1, 16'sd1);
   endtask

   task automatic test_special_quats();
      // -2 component, conjugate gives +2
      set_quat(16'sh8000, 16'sd0, 16'sd0, 16'sd0);
      send_vector(1'b1, 16'sd1, 16'sd1, 16'sd1);
      send_vector(1'b0, 16'sd100, -16'sd100, 16'sd50);
      send_vector(1'b1, 16'sh7fff, 16'sh7fff, 16'sh8000);
      // non-unit, saturates
      set_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_vector(1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_vector(1'b1, 16'sh8000, 16'sd100, 16'sd5);
      send_vector(1'b0, 16'sd1, 16'sd2, 16'sd3);
      set_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_vector(1'b0, 16'sd1000, -16'sd1000, 16'sd1);
      send_vector(1'b1, 16'sd1, 16'sd0, 16'sd0);
   endtask

   task automatic test_random_rotations();
      logic burst;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            2: set_quat(QW'($signed($urandom_range(0, 32768)) - 16384),
                        QW'($signed($urandom_range(0, 32768)) - 16384),
                        QW'($signed($urandom_range(0, 32768)) - 16384),
                        QW'($signed($urandom_range(0, 32768)) - 16384));
            3: set_quat(QW'($urandom), QW'($urandom), QW'($urandom), QW'($urandom));
            default: set_random_unit_quat();
         endcase
         burst = (phase % 3 == 1);
         for (int i = 0; i < 80; i++) begin
            send_vector(1'($urandom_range(0, 1)), random_component(), random_component(),
                        random_component());
            if (phase == 4 && i == 40)
               wait_drained();
            else if (!burst)
               idle_sender(random_gap());
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rotations.size() == 0) begin
            report_mismatch("unexpected word rot_x", rsp_rot_x, 0);
         end else begin
            want_word = pending_rotations.pop_front();
            if (rsp_rot_x !== want_word.x)
               report_mismatch("rot_x", rsp_rot_x, want_word.x);
            if (rsp_rot_y !== want_word.y)
               report_mismatch("rot_y", rsp_rot_y, want_word.y);
            if (rsp_rot_z !== want_word.z)
               report_mismatch("rot_z", rsp_rot_z, want_word.z);
            if (rsp_clipped !== want_word.clip)
               report_mismatch("clipped", rsp_clipped, want_word.clip);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      quat_cfg[qrv_pkg::CSR_QUAT_X] = '0;
      quat_cfg[qrv_pkg::CSR_QUAT_Y] = '0;
      quat_cfg[qrv_pkg::CSR_QUAT_Z] = '0;
      quat_cfg[qrv_pkg::CSR_QUAT_W] = QW'(1 << FB);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_identity();
      test_fixed_turns();
      test_special_quats();
      test_random_rotations();
      wait_drained();
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
